// ===== rtl/tlf_pkg.sv =====
`timescale 1ns / 1ps

package tlf_pkg;

  // segment buffer depth and derived widths
  localparam int MAX_WIDTH = 32;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int FOLD_W    = 6;

  localparam logic [FOLD_W-1:0] FOLD_RESET = FOLD_W'(15);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
  } tlf_item_t;

endpackage

// ===== rtl/tlf_obuf.sv =====
`timescale 1ns / 1ps

module tlf_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  tlf_pkg::tlf_item_t item,
  output logic [1:0]         level,
  output logic               fold_valid,
  input  logic               fold_stall,
  output logic [7:0]         char_out,
  output logic               last_of_run,
  output logic               stream_done
);
  import tlf_pkg::*;

  logic      out_valid;
  logic      skid_valid;
  tlf_item_t out_item;
  tlf_item_t skid_item;
  logic      pop;

  assign pop = out_valid && !fold_stall;

  // occupancy left after this cycle's transaction, not counting the arriving item
  assign level = {1'b0, out_valid} + {1'b0, skid_valid} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_item   <= skid_item;
        skid_valid <= item_valid;
        skid_item  <= item;
      end else begin
        out_valid <= item_valid;
        out_item  <= item;
      end
    end else if (item_valid) begin
      skid_valid <= 1'b1;
      skid_item  <= item;
    end
  end

  assign fold_valid  = out_valid;
  assign char_out    = out_item.ch;
  assign last_of_run = out_item.last;
  assign stream_done = out_item.done;

endmodule

// ===== rtl/text_line_folder_top.sv =====
`timescale 1ns / 1ps

// channel   | handshake                 | payload
// text      | text_valid / text_stall   | char_in, end_of_text
// fold      | fold_valid / fold_stall   | char_out, last_of_run, stream_done
// config    | cfg_write                 | cfg_data (fold_width)
//
// An input transaction is taken while the sequencer is idle; its results are then issued one per
// cycle while the fold side does not stall (pending newline first, then the buffered bytes
// read from the segment RAM). The single RAM read port sets this rate.
// The output register plus a skid entry let the next input be taken while results wait.
// Reset is synchronous; no clearing pass, the segment RAM is only read where written.
// A stall on the fold side pauses the read sequencer without losing in-flight data.

module text_line_folder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [5:0] cfg_data,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] char_in,
  input  logic       end_of_text,
  output logic       fold_valid,
  input  logic       fold_stall,
  output logic [7:0] char_out,
  output logic       last_of_run,
  output logic       stream_done
);
  import tlf_pkg::*;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // line state
  logic [FOLD_W-1:0] fold_width;
  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] brk;
  logic [ADDR_W-1:0] sp_run;
  logic              run_open;
  logic              pvb;
  logic              skip;
  logic              nlp;

  logic [ADDR_W-1:0] base_next;
  logic [CNT_W-1:0]  fill_next;
  logic [ADDR_W-1:0] brk_next;
  logic [ADDR_W-1:0] sp_run_next;
  logic              run_open_next;
  logic              pvb_next;
  logic              skip_next;
  logic              nlp_next;

  // emit job
  state_t            state;
  logic              job_nl;
  logic [CNT_W-1:0]  job_cnt;
  logic [ADDR_W-1:0] job_ptr;
  logic              job_eot;
  logic              job_nl_next;
  logic [CNT_W-1:0]  job_cnt_next;
  logic              job_eot_next;

  logic              accept;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  w_eff;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W-1:0]  start;
  logic [CNT_W-1:0]  keep;
  logic              blank;

  // read pipeline
  logic [7:0]        seg_mem [MAX_WIDTH];
  logic [7:0]        mem_q;
  logic              rd_pend;
  logic              p1_from_mem;
  logic              p1_last;
  logic              p1_done;
  logic              issue;
  logic              issue_last;
  logic [1:0]        obuf_level;
  tlf_item_t         p1_item;

  assign text_stall = (state != ST_IDLE);
  assign accept     = text_valid && !text_stall;
  assign blank      = is_blank(char_in);
  assign fill_inc   = fill + CNT_W'(1);
  assign wr_addr    = base + fill[ADDR_W-1:0];

  always_comb begin
    if (fold_width == '0) begin
      w_eff = CNT_W'(1);
    end else if (CNT_W'(fold_width) > CNT_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(fold_width);
    end
  end

  always_comb begin
    base_next     = base;
    fill_next     = fill;
    brk_next      = brk;
    sp_run_next   = sp_run;
    run_open_next = run_open;
    pvb_next      = pvb;
    skip_next     = skip;
    nlp_next      = nlp;
    job_nl_next   = 1'b0;
    job_cnt_next  = '0;
    job_eot_next  = 1'b0;
    wr_en         = 1'b0;
    start         = '0;
    keep          = '0;
    if (end_of_text) begin
      job_nl_next   = nlp && (fill != '0);
      job_cnt_next  = fill;
      job_eot_next  = 1'b1;
      fill_next     = '0;
      brk_next      = '0;
      sp_run_next   = '0;
      run_open_next = 1'b0;
      pvb_next      = 1'b1;
      skip_next     = 1'b0;
      nlp_next      = 1'b0;
    end else if (!(skip && char_in == CH_SPACE)) begin
      skip_next = 1'b0;
      if (char_in == CH_NL) begin
        job_nl_next   = nlp;
        job_cnt_next  = fill;
        nlp_next      = 1'b1;
        fill_next     = '0;
        brk_next      = '0;
        run_open_next = 1'b0;
        pvb_next      = 1'b0;
      end else begin
        wr_en    = 1'b1;
        pvb_next = blank;
        // track the space run right after the last break so the fold
        // knows where the carried text starts without rescanning
        if (blank && !pvb) begin
          brk_next      = fill[ADDR_W-1:0];
          sp_run_next   = '0;
          run_open_next = 1'b1;
        end else if (run_open && char_in == CH_SPACE) begin
          sp_run_next = sp_run + ADDR_W'(1);
        end else begin
          run_open_next = 1'b0;
        end
        fill_next = fill_inc;
        if (fill_inc >= w_eff) begin
          if (brk_next != '0) begin
            job_cnt_next = CNT_W'(brk_next);
            start        = CNT_W'(brk_next) + CNT_W'(1) + CNT_W'(sp_run_next);
          end else begin
            job_cnt_next = fill_inc;
            start        = fill_inc;
          end
          keep          = fill_inc - start;
          job_nl_next   = nlp;
          base_next     = base + start[ADDR_W-1:0];
          fill_next     = keep;
          brk_next      = '0;
          sp_run_next   = '0;
          run_open_next = 1'b0;
          // no break can lie in the carried part: the old break was the last one
          pvb_next      = ((brk_next != '0) && (keep == '0)) ? 1'b1 : blank;
          skip_next     = (keep == '0);
          nlp_next      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_width <= FOLD_RESET;
      base       <= '0;
      fill       <= '0;
      brk        <= '0;
      sp_run     <= '0;
      run_open   <= 1'b0;
      pvb        <= 1'b1;
      skip       <= 1'b0;
      nlp        <= 1'b0;
    end else begin
      if (cfg_write) begin
        fold_width <= cfg_data;
      end
      if (accept) begin
        base     <= base_next;
        fill     <= fill_next;
        brk      <= brk_next;
        sp_run   <= sp_run_next;
        run_open <= run_open_next;
        pvb      <= pvb_next;
        skip     <= skip_next;
        nlp      <= nlp_next;
      end
    end
  end

  // segment RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      seg_mem[wr_addr] <= char_in;
    end
    mem_q <= seg_mem[job_ptr];
  end

  assign issue      = (state == ST_EMIT) && ((CNT_W'(obuf_level) + CNT_W'(rd_pend)) <= CNT_W'(1));
  assign issue_last = job_nl ? (job_cnt == '0) : (job_cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      job_nl  <= 1'b0;
      job_cnt <= '0;
      job_eot <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            job_nl  <= job_nl_next;
            job_cnt <= job_cnt_next;
            job_eot <= job_eot_next;
            job_ptr <= base;
            if (job_nl_next || job_cnt_next != '0) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (issue) begin
            if (job_nl) begin
              job_nl <= 1'b0;
            end else begin
              job_ptr <= job_ptr + ADDR_W'(1);
              job_cnt <= job_cnt - CNT_W'(1);
            end
            if (issue_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // side info for the item whose RAM data lands next cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      p1_from_mem <= !job_nl;
      p1_last     <= issue_last;
      p1_done     <= issue_last && job_eot;
    end
  end

  assign p1_item.ch   = p1_from_mem ? mem_q : CH_NL;
  assign p1_item.last = p1_last;
  assign p1_item.done = p1_done;

  tlf_obuf u_obuf (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (rd_pend),
    .item        (p1_item),
    .level       (obuf_level),
    .fold_valid  (fold_valid),
    .fold_stall  (fold_stall),
    .char_out    (char_out),
    .last_of_run (last_of_run),
    .stream_done (stream_done)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_pend && obuf_level == 2'd2))
    else $error("output buffer overflow");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    fold_valid && stream_done |-> last_of_run)
    else $error("stream_done without last_of_run");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill < CNT_W'(MAX_WIDTH))
    else $error("segment fill out of range");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_stall && end_of_text |=> fill == '0 && !nlp)
    else $error("end of text left line state");
`endif

endmodule
